// ===== src/pcp_pkg.sv =====
// Package for the pinhole camera projection block: coordinate and datapath widths,
// channel payload types and the built-in camera intrinsics table.
// No dependencies; every other file of the block imports it.
package pcp_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int COORD_WIDTH = 28;
   localparam int INTR_FRAC   = 16;
   localparam int INTR_W      = 26;

   // Magnitude of (u << INTR_FRAC) - (cu << FRAC_BITS), plus one bit of headroom.
   localparam int MAG_HI = ((COORD_WIDTH - 1 + INTR_FRAC) > (INTR_W + FRAC_BITS)) ?
                           (COORD_WIDTH - 1 + INTR_FRAC) : (INTR_W + FRAC_BITS);
   localparam int MAG_W  = MAG_HI + 1;
   localparam int LO_W   = MAG_W / 2;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int ZW     = (COORD_WIDTH > INTR_W) ? COORD_WIDTH : INTR_W;
   localparam int NUM_W  = MAG_W + ZW;
   localparam int DEN_W  = ((INTR_W + FRAC_BITS) > (COORD_WIDTH + INTR_FRAC - FRAC_BITS)) ?
                           (INTR_W + FRAC_BITS) : (COORD_WIDTH + INTR_FRAC - FRAC_BITS);
   // One extra quotient bit flags a quotient at or above 2^COORD_WIDTH.
   localparam int QUOT_W     = COORD_WIDTH + 1;
   localparam int DIV_STAGES = QUOT_W;

   localparam logic       ACT_BACK = 1'b0;
   localparam logic       ACT_PROJ = 1'b1;
   localparam logic [1:0] CAM_0    = 2'd0;
   localparam logic [1:0] CAM_1    = 2'd1;
   localparam logic [1:0] CAM_2    = 2'd2;
   localparam logic [1:0] CAM_3    = 2'd3;

   typedef struct packed {
      logic                          action;
      logic [1:0]                    camera_sel;
      logic signed [COORD_WIDTH-1:0] coord_a;
      logic signed [COORD_WIDTH-1:0] coord_b;
      logic signed [COORD_WIDTH-1:0] coord_c;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_a;
      logic signed [COORD_WIDTH-1:0] out_b;
      logic signed [COORD_WIDTH-1:0] out_c;
      logic                          div_error;
   } rsp_type;

   // Intrinsics in unsigned Q16.
   typedef struct packed {
      logic [INTR_W-1:0] cu;
      logic [INTR_W-1:0] cv;
      logic [INTR_W-1:0] fx;
      logic [INTR_W-1:0] fy;
   } intr_type;

   function automatic intr_type intr_lookup(input logic [1:0] cam);
      intr_type k;
      unique case (cam)
         CAM_0: k = '{INTR_W'(41621558), INTR_W'(28219942),
                      INTR_W'(59603340), INTR_W'(59687080)};
         CAM_1: k = '{INTR_W'(10242717), INTR_W'(7722927),
                      INTR_W'(14916583), INTR_W'(14935806)};
         CAM_2, CAM_3: k = '{INTR_W'(10725858), INTR_W'(6935879),
                             INTR_W'(14923815), INTR_W'(14935875)};
         default: k = '{INTR_W'(10725858), INTR_W'(6935879),
                        INTR_W'(14923815), INTR_W'(14935875)};
      endcase
      return k;
   endfunction

endpackage

// ===== src/pcp_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on pcp_pkg for the numerator, denominator and quotient widths.
module pcp_divider import pcp_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num_in,
   input  logic [DEN_W-1:0]  den_in,
   output logic [QUOT_W-1:0] quot_out
);

   logic [NUM_W-1:0]  rem_ff  [DIV_STAGES-1];
   logic [DEN_W-1:0]  den_ff  [DIV_STAGES-1];
   logic [QUOT_W-1:0] quot_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      localparam int B = QUOT_W - 1 - k;
      logic [NUM_W-1:0]   rem_prev;
      logic [DEN_W-1:0]   den_prev;
      logic [QUOT_W-1:0]  quot_prev;
      logic [NUM_W-B-1:0] upper;
      logic [NUM_W-B-1:0] diff;
      logic               ge;
      logic [QUOT_W-1:0]  quot_in;

      if (k == 0) begin : g_first
         assign rem_prev  = num_in;
         assign den_prev  = den_in;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quot_prev = quot_ff[k-1];
      end

      // Comparing rem >> B with den is the same test as rem >= den << B.
      assign upper = rem_prev[NUM_W-1:B];
      assign ge    = upper >= (NUM_W-B)'(den_prev);
      assign diff  = upper - (NUM_W-B)'(den_prev);

      always_comb begin
         quot_in    = quot_prev;
         quot_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quot_ff[k] <= quot_in;
         end
      end

      if (k < DIV_STAGES - 1) begin : g_rem
         logic [NUM_W-1:0] rem_in;
         if (B > 0) begin : g_low
            assign rem_in = ge ? {diff, rem_prev[B-1:0]} : rem_prev;
         end else begin : g_nolow
            assign rem_in = ge ? diff : rem_prev;
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quot_out = quot_ff[DIV_STAGES-1];

endmodule

// ===== src/pinhole_camera_projection.sv =====
// Pinhole camera back-projection and projection with built-in intrinsics.
// Input channel req_valid / req_stall / req_data carries one item per transfer:
// action (back-project or project), camera id and three Q8 coordinates.
// Result channel rsp_valid / rsp_stall / rsp_data returns one result per item,
// in order: two converted coordinates, z passed through, and div_error when a
// projection meets zero depth (then all coordinates are zero).
// Throughput is one item per clock while the receiver does not stall a waiting
// result. Pipeline stages: one stage forms operands, two build the product from
// split partial products, COORD_WIDTH + 1 stages run the pipelined divider one
// quotient bit each, and one stage adds the principal point and saturates.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// A result waiting in the output register does not block a new transfer as
// long as the receiver takes it in the same cycle.
// Reset is synchronous and clears all valid bits; no stored item survives it.
// Camera id three uses the intrinsics of camera two.
// Depends on pcp_pkg and pcp_divider.
module pinhole_camera_projection import pcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = COORD_WIDTH;
   localparam int NS = DIV_STAGES + 4;
   localparam int SW = CW + INTR_W + 2;

   typedef struct packed {
      logic              err;
      logic              neg_a;
      logic              neg_b;
      logic [INTR_W-1:0] off_a;
      logic [INTR_W-1:0] off_b;
      logic [CW-1:0]     coord_c;
   } meta_type;

   function automatic logic [CW-1:0] mag_coord(input logic [CW-1:0] v);
      return v[CW-1] ? CW'(-v) : v;
   endfunction

   function automatic logic [MAG_W-1:0] back_mag(input logic [CW-1:0] p,
                                                 input logic [INTR_W-1:0] c,
                                                 output logic neg);
      logic signed [MAG_W:0] s;
      s = ($signed({{(MAG_W+1-CW){p[CW-1]}}, p}) <<< INTR_FRAC)
          - $signed({1'b0, MAG_W'(c) << FRAC_BITS});
      neg = s[MAG_W];
      return s[MAG_W] ? MAG_W'(-s) : MAG_W'(s);
   endfunction

   logic advance;
   logic [NS-1:0] valid_ff;

   assign advance   = !(valid_ff[NS-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], req_valid};
      end
   end

   // Stage 1: operands.
   intr_type          k_in;
   meta_type          s1_meta_in, s1_meta_ff;
   logic [MAG_W-1:0]  s1_mag_a_in, s1_mag_b_in, s1_mag_a_ff, s1_mag_b_ff;
   logic [ZW-1:0]     s1_mul_a_in, s1_mul_b_in, s1_mul_a_ff, s1_mul_b_ff;
   logic [DEN_W-1:0]  s1_den_a_in, s1_den_b_in, s1_den_a_ff, s1_den_b_ff;
   logic [CW-1:0]     zmag;
   logic              neg_pa, neg_pb, z_neg;

   always_comb begin
      k_in   = intr_lookup(req_data.camera_sel);
      zmag   = mag_coord(req_data.coord_c);
      z_neg  = req_data.coord_c[CW-1];
      neg_pa = 1'b0;
      neg_pb = 1'b0;
      s1_meta_in.coord_c = req_data.coord_c;
      s1_meta_in.err     = 1'b0;
      if (req_data.action == ACT_BACK) begin
         s1_mag_a_in = back_mag(req_data.coord_a, k_in.cu, neg_pa);
         s1_mag_b_in = back_mag(req_data.coord_b, k_in.cv, neg_pb);
         s1_mul_a_in = ZW'(zmag);
         s1_mul_b_in = ZW'(zmag);
         s1_den_a_in = DEN_W'(k_in.fx) << FRAC_BITS;
         s1_den_b_in = DEN_W'(k_in.fy) << FRAC_BITS;
         s1_meta_in.off_a = '0;
         s1_meta_in.off_b = '0;
      end else begin
         s1_mag_a_in = MAG_W'(mag_coord(req_data.coord_a));
         s1_mag_b_in = MAG_W'(mag_coord(req_data.coord_b));
         neg_pa      = req_data.coord_a[CW-1];
         neg_pb      = req_data.coord_b[CW-1];
         s1_mul_a_in = ZW'(k_in.fx);
         s1_mul_b_in = ZW'(k_in.fy);
         // x*(fx<<F)/(z<<16) has the same floor as x*fx/(z<<(16-F)).
         s1_den_a_in = DEN_W'(zmag) << (INTR_FRAC - FRAC_BITS);
         s1_den_b_in = DEN_W'(zmag) << (INTR_FRAC - FRAC_BITS);
         s1_meta_in.off_a = k_in.cu >> (INTR_FRAC - FRAC_BITS);
         s1_meta_in.off_b = k_in.cv >> (INTR_FRAC - FRAC_BITS);
         s1_meta_in.err   = (req_data.coord_c == '0);
      end
      s1_meta_in.neg_a = neg_pa ^ z_neg;
      s1_meta_in.neg_b = neg_pb ^ z_neg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_meta_ff  <= s1_meta_in;
         s1_mag_a_ff <= s1_mag_a_in;
         s1_mag_b_ff <= s1_mag_b_in;
         s1_mul_a_ff <= s1_mul_a_in;
         s1_mul_b_ff <= s1_mul_b_in;
         s1_den_a_ff <= s1_den_a_in;
         s1_den_b_ff <= s1_den_b_in;
      end
   end

   // Stage 2: partial products of the split magnitude.
   meta_type             s2_meta_ff;
   logic [LO_W+ZW-1:0]   s2_pl_a_ff, s2_pl_b_ff;
   logic [HI_W+ZW-1:0]   s2_ph_a_ff, s2_ph_b_ff;
   logic [DEN_W-1:0]     s2_den_a_ff, s2_den_b_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_meta_ff  <= s1_meta_ff;
         s2_pl_a_ff  <= (LO_W+ZW)'(s1_mag_a_ff[LO_W-1:0]) * (LO_W+ZW)'(s1_mul_a_ff);
         s2_pl_b_ff  <= (LO_W+ZW)'(s1_mag_b_ff[LO_W-1:0]) * (LO_W+ZW)'(s1_mul_b_ff);
         s2_ph_a_ff  <= (HI_W+ZW)'(s1_mag_a_ff[MAG_W-1:LO_W]) * (HI_W+ZW)'(s1_mul_a_ff);
         s2_ph_b_ff  <= (HI_W+ZW)'(s1_mag_b_ff[MAG_W-1:LO_W]) * (HI_W+ZW)'(s1_mul_b_ff);
         s2_den_a_ff <= s1_den_a_ff;
         s2_den_b_ff <= s1_den_b_ff;
      end
   end

   // Stage 3: full numerator.
   meta_type          s3_meta_ff;
   logic [NUM_W-1:0]  s3_num_a_ff, s3_num_b_ff;
   logic [DEN_W-1:0]  s3_den_a_ff, s3_den_b_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_meta_ff  <= s2_meta_ff;
         s3_num_a_ff <= {s2_ph_a_ff, {LO_W{1'b0}}} + NUM_W'(s2_pl_a_ff);
         s3_num_b_ff <= {s2_ph_b_ff, {LO_W{1'b0}}} + NUM_W'(s2_pl_b_ff);
         s3_den_a_ff <= s2_den_a_ff;
         s3_den_b_ff <= s2_den_b_ff;
      end
   end

   // Divider stages; side information travels alongside.
   logic [QUOT_W-1:0] quot_a, quot_b;
   meta_type          div_meta_ff [DIV_STAGES];

   pcp_divider u_div_a (
      .clock    (clock),
      .advance  (advance),
      .num_in   (s3_num_a_ff),
      .den_in   (s3_den_a_ff),
      .quot_out (quot_a)
   );

   pcp_divider u_div_b (
      .clock    (clock),
      .advance  (advance),
      .num_in   (s3_num_b_ff),
      .den_in   (s3_den_b_ff),
      .quot_out (quot_b)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         div_meta_ff[0] <= s3_meta_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            div_meta_ff[i] <= div_meta_ff[i-1];
         end
      end
   end

   // Output stage: sign, principal point offset and saturation.
   function automatic logic [CW-1:0] finish(input logic [QUOT_W-1:0] q,
                                            input logic neg,
                                            input logic [INTR_W-1:0] off);
      logic [CW:0]          m;
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      m  = q[CW] ? {1'b1, {CW{1'b0}}} : {1'b0, q[CW-1:0]};
      s  = neg ? -$signed(SW'(m)) : $signed(SW'(m));
      s  = s + $signed(SW'(off));
      hi = $signed(SW'({1'b0, {(CW-1){1'b1}}}));
      lo = -hi - $signed(SW'(1));
      if (s > hi) begin
         return CW'(hi);
      end else if (s < lo) begin
         return CW'(lo);
      end
      return CW'(s);
   endfunction

   meta_type fin_meta;
   rsp_type  rsp_in, rsp_ff;

   always_comb begin
      fin_meta = div_meta_ff[DIV_STAGES-1];
      if (fin_meta.err) begin
         rsp_in.out_a     = '0;
         rsp_in.out_b     = '0;
         rsp_in.out_c     = '0;
         rsp_in.div_error = 1'b1;
      end else begin
         rsp_in.out_a     = finish(quot_a, fin_meta.neg_a, fin_meta.off_a);
         rsp_in.out_b     = finish(quot_b, fin_meta.neg_b, fin_meta.off_b);
         rsp_in.out_c     = fin_meta.coord_c;
         rsp_in.div_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_error) |->
         (rsp_data.out_a == '0 && rsp_data.out_b == '0 && rsp_data.out_c == '0))
      else $error("div_error result with nonzero coordinates");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved during an output stall");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== bench/pinhole_camera_projection_checker.sv =====
// Checker for the pinhole camera projection block: watches both channels, computes
// the expected conversion of each accepted item and compares results in order.
// Depends on pcp_pkg for the payload types and coordinate width.
`timescale 1ns / 100ps

module pinhole_camera_projection_checker import pcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint QUOT_LIM  = 64'sd1 <<< COORD_WIDTH;

   // Intrinsics per camera in unsigned Q16: cu, cv, fx, fy.
   localparam longint CAM_CU [3] = '{41621558, 10242717, 10725858};
   localparam longint CAM_CV [3] = '{28219942, 7722927, 6935879};
   localparam longint CAM_FX [3] = '{59603340, 14916583, 14923815};
   localparam longint CAM_FY [3] = '{59687080, 14935806, 14935875};

   rsp_type expected_q[$];

   function automatic logic [127:0] magnitude(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Quotient is clamped well outside the coordinate range before its sign is applied.
   function automatic longint signed_quotient(logic [127:0] q, logic neg);
      longint m;
      m = (q > 128'(QUOT_LIM)) ? QUOT_LIM : longint'(q[63:0]);
      return neg ? -m : m;
   endfunction

   function automatic longint back_axis(longint p, longint ctr, longint foc, longint z);
      longint offset;
      logic [127:0] prod;
      offset = p * 65536 - ctr * 256;
      prod = magnitude(offset) * magnitude(z);
      return clamp_coord(signed_quotient(prod / 128'(foc * 256),
                                         (offset < 0) != (z < 0)));
   endfunction

   function automatic longint proj_axis(longint p, longint ctr, longint foc, longint z);
      logic [127:0] prod;
      longint q;
      prod = magnitude(p) * 128'(foc * 256);
      q = signed_quotient(prod / (magnitude(z) << 16), (p < 0) != (z < 0));
      return clamp_coord(q + (ctr >>> 8));
   endfunction

   function automatic rsp_type convert_point(req_type r);
      int cam;
      longint a, b, c;
      rsp_type o;
      cam = (r.camera_sel > CAM_2) ? 2 : int'(r.camera_sel);
      a = longint'(r.coord_a);
      b = longint'(r.coord_b);
      c = longint'(r.coord_c);
      o = '0;
      if (r.action == ACT_BACK) begin
         o.out_a = COORD_WIDTH'(back_axis(a, CAM_CU[cam], CAM_FX[cam], c));
         o.out_b = COORD_WIDTH'(back_axis(b, CAM_CV[cam], CAM_FY[cam], c));
         o.out_c = r.coord_c;
      end else if (c == 0) begin
         o.div_error = 1'b1;
      end else begin
         o.out_a = COORD_WIDTH'(proj_axis(a, CAM_CU[cam], CAM_FX[cam], c));
         o.out_b = COORD_WIDTH'(proj_axis(b, CAM_CV[cam], CAM_FY[cam], c));
         o.out_c = r.coord_c;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transfer: %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_q.pop_front();
               if (exp_rsp.out_a !== rsp_data.out_a || exp_rsp.out_b !== rsp_data.out_b ||
                   exp_rsp.out_c !== rsp_data.out_c ||
                   exp_rsp.div_error !== rsp_data.div_error) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0d %b, got %0d %0d %0d %b",
                              exp_rsp.out_a, exp_rsp.out_b, exp_rsp.out_c, exp_rsp.div_error,
                              rsp_data.out_a, rsp_data.out_b, rsp_data.out_c,
                              rsp_data.div_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(), convert_point(req_data));
         pending <= expected_q.size();
      end
   end

endmodule

// ===== bench/pinhole_camera_projection_tb.sv =====
// Top of the pinhole camera projection bench: clock, reset, stimulus with random
// idling on both channels, a watchdog and the final verdict.
// Depends on pcp_pkg, the block and pinhole_camera_projection_checker.
`timescale 1ns / 100ps

module pinhole_camera_projection_tb;
   import pcp_pkg::*;

   localparam int C_MAX = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int C_MIN = -C_MAX - 1;
   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      sender_idle_pct;
   int      receiver_stall_pct;
   int      quiet_cycles;

   pinhole_camera_projection u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   pinhole_camera_projection_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pinhole_camera_projection regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(req_type item);
      logic stalled;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   function automatic req_type make_item(logic act, logic [1:0] cam, int a, int b, int c);
      req_type r;
      r.action = act;
      r.camera_sel = cam;
      r.coord_a = COORD_WIDTH'(a);
      r.coord_b = COORD_WIDTH'(b);
      r.coord_c = COORD_WIDTH'(c);
      return r;
   endfunction

   // Mostly plausible pixels, depths and world points; the rest is full-range noise.
   function automatic req_type random_item();
      req_type r;
      logic act;
      logic [1:0] cam;
      act = 1'($urandom_range(1));
      cam = 2'($urandom_range(2));
      if ($urandom_range(99) < 20) begin
         r = make_item(act, cam, int'($urandom), int'($urandom), int'($urandom));
         if ($urandom_range(9) == 0)
            r.coord_c = '0;
      end else if (act == ACT_BACK) begin
         r = make_item(act, cam, int'($urandom_range(1280 * 256 - 1)),
                       int'($urandom_range(960 * 256 - 1)),
                       int'($urandom_range(20000 * 256)));
      end else begin
         r = make_item(act, cam, int'($urandom_range(40000 * 256)) - 20000 * 256,
                       int'($urandom_range(40000 * 256)) - 20000 * 256,
                       int'($urandom_range(20000 * 256))
                       - (($urandom_range(9) == 0) ? 10000 * 256 : 0));
         if ($urandom_range(19) == 0)
            r.coord_c = '0;
      end
      return r;
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sender_idle_pct = 8;
      receiver_stall_pct = 62;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Extremes, both modes, cameras 0 to 2, zero and negative depth.
      send_item(make_item(ACT_BACK, CAM_0, 320 << 8, 240 << 8, 1000 << 8));
      send_item(make_item(ACT_BACK, CAM_1, 0, 0, 1 << 8));
      send_item(make_item(ACT_BACK, CAM_2, 639 << 8, 479 << 8, 5000 << 8));
      send_item(make_item(ACT_BACK, CAM_0, C_MAX, C_MAX, C_MAX));
      send_item(make_item(ACT_BACK, CAM_1, C_MIN, C_MIN, C_MAX));
      send_item(make_item(ACT_BACK, CAM_2, C_MIN, C_MAX, C_MIN));
      send_item(make_item(ACT_BACK, CAM_0, 100 << 8, 50 << 8, 0));
      send_item(make_item(ACT_BACK, CAM_1, 100 << 8, 50 << 8, -(300 << 8)));
      send_item(make_item(ACT_BACK, CAM_2, -1, -1, -1));
      send_item(make_item(ACT_PROJ, CAM_0, 100 << 8, -(50 << 8), 1000 << 8));
      send_item(make_item(ACT_PROJ, CAM_1, 0, 0, 1));
      send_item(make_item(ACT_PROJ, CAM_2, 10 << 8, 10 << 8, 0));
      send_item(make_item(ACT_PROJ, CAM_0, C_MAX, C_MIN, 0));
      send_item(make_item(ACT_PROJ, CAM_0, C_MAX, C_MAX, 1));
      send_item(make_item(ACT_PROJ, CAM_1, C_MIN, C_MIN, 1));
      send_item(make_item(ACT_PROJ, CAM_2, C_MIN, C_MAX, C_MIN));
      send_item(make_item(ACT_PROJ, CAM_2, C_MAX, C_MIN, C_MAX));
      send_item(make_item(ACT_PROJ, CAM_1, 200 << 8, 300 << 8, -(700 << 8)));
      send_item(make_item(ACT_PROJ, CAM_0, -1, -1, -1));

      for (int i = 0; i < 1550; i++) begin
         if (i == 520) begin
            sender_idle_pct = 62;
            receiver_stall_pct = 8;
         end else if (i == 1040) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         send_item(random_item());
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("pinhole_camera_projection regression: pass");
      else
         $display("pinhole_camera_projection regression: fail");
      $finish;
   end

endmodule
